### rtl/core/xsr_pkg.sv
// Package for the xorshift1024* ranged draw block.
// Holds widths, the multiplier, register indexes, mode codes and the
// controller command struct. No dependencies.
package xsr_pkg;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned POOL_N    = 16;
  localparam int unsigned PTR_W     = 4;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [63:0] MULT = 64'd1181783497276652981;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FULL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_T32  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_T16  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_T8   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RNG  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed_wr;     // write seed word, clear pointer
    logic rd_s0;       // issue read of pool[ptr]
    logic rd_s1;       // capture s0, advance pointer, issue read of pool[ptr]
    logic mix;         // capture s1, compute new word, write it back
    logic mul_start;   // start the 64x64 multiply of the new word
    logic div_start;   // start buckets = ~0 / span
    logic quo_start;   // start product / buckets
    logic lim_start;   // start limit = buckets * span
    logic out_load;    // load shaped result into the output register
  } xsr_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic span_zero;
    logic reject;
  } xsr_sts_t;
endpackage

### rtl/core/xsr_if.sv
// Valid/ready stream interface used for the request and result channels.
// Depends on nothing; the payload width is a parameter.
interface xsr_if #(parameter int unsigned W = 64) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/xsr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module xsr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### rtl/core/xsr_datapath.sv
// Datapath: pool RAM, pointer, xorshift mix, serial multiplier and serial
// divider, output shaping. Depends on xsr_pkg and xsr_ram.
module xsr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  xsr_pkg::xsr_cmd_t             cmd,
  output xsr_pkg::xsr_sts_t             sts,
  input  logic [xsr_pkg::PTR_W-1:0]     seed_index,
  input  logic [xsr_pkg::WORD_W-1:0]    seed_value,
  input  logic [xsr_pkg::MODE_W-1:0]    mode,
  input  logic [xsr_pkg::WORD_W-1:0]    range_low,
  input  logic [xsr_pkg::WORD_W-1:0]    range_high,
  output logic [xsr_pkg::WORD_W-1:0]    result
);
  import xsr_pkg::*;

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [WORD_W-1:0] s0_r, rdata, new_word;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata, s1x;
  logic [POOL_N-1:0] wr_vld_r;
  logic              rd_vld_r;
  logic [WORD_W-1:0] rword;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.seed_wr) ptr_nxt = '0;
    else if (cmd.rd_s1) ptr_nxt = ptr_r + 1'b1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) ptr_r <= '0;
    else        ptr_r <= ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_s1) s0_r <= rword;
  end

  assign s1x      = rword ^ (rword << 31);
  assign new_word = s1x ^ s0_r ^ (s1x >> 11) ^ (s0_r >> 30);

  always_comb begin
    ram_we    = cmd.seed_wr | cmd.mix;
    ram_addr  = cmd.seed_wr ? seed_index : (cmd.rd_s1 ? ptr_nxt : ptr_r);
    ram_wdata = cmd.seed_wr ? seed_value : new_word;
  end

  xsr_ram #(.WIDTH(WORD_W), .DEPTH(POOL_N)) u_pool (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(rdata)
  );

  // A pool word that has not been written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= wr_vld_r[ram_addr];
      if (ram_we) wr_vld_r[ram_addr] <= 1'b1;
    end
  end
  assign rword = rd_vld_r ? rdata : '0;

  // Shift-add multiplier, 16 bits per cycle, mod 2^64.
  // Shared for word*MULT and buckets*span.
  logic [WORD_W-1:0] ma_r, mb_r, macc_r, prod_r;
  logic [2:0]        mcnt_r;
  logic              mbusy_r, mdone_r;
  logic [WORD_W-1:0] span, buckets_r;
  logic [WORD_W-1:0] part;

  assign span = range_high - range_low + 64'd1;
  assign part = ma_r * {48'd0, mb_r[15:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.mul_start || cmd.lim_start) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r == 3'd3) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r <= new_word; mb_r <= MULT; macc_r <= '0;
    end else if (cmd.lim_start) begin
      ma_r <= buckets_r; mb_r <= span; macc_r <= '0;
    end else if (mbusy_r) begin
      macc_r <= macc_r + part;
      ma_r   <= ma_r << 16;
      mb_r   <= mb_r >> 16;
    end
  end
  logic [WORD_W-1:0] limit_r;
  logic              mul_is_lim_r;
  always_ff @(posedge clk) begin
    if (cmd.mul_start) mul_is_lim_r <= 1'b0;
    else if (cmd.lim_start) mul_is_lim_r <= 1'b1;
    if (mbusy_r && mcnt_r == 3'd3) begin
      if (mul_is_lim_r) limit_r <= macc_r + part;
      else              prod_r  <= macc_r + part;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [WORD_W-1:0] dq_r, dd_r;
  logic [WORD_W:0]   drem_r, dtrial;
  logic [6:0]        dcnt_r;
  logic              dbusy_r, ddone_r, div_is_q_r;
  logic [WORD_W:0]   dshift;

  assign dshift = {drem_r[WORD_W-1:0], dq_r[WORD_W-1]};
  assign dtrial = dshift - {1'b0, dd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      ddone_r <= 1'b0;
      if (cmd.div_start || cmd.quo_start) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 7'(WORD_W - 1)) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r <= '1; dd_r <= span; drem_r <= '0; div_is_q_r <= 1'b0;
    end else if (cmd.quo_start) begin
      dq_r <= prod_r; dd_r <= buckets_r; drem_r <= '0; div_is_q_r <= 1'b1;
    end else if (dbusy_r) begin
      if (!dtrial[WORD_W]) begin
        drem_r <= dtrial;
        dq_r   <= {dq_r[WORD_W-2:0], 1'b1};
      end else begin
        drem_r <= dshift;
        dq_r   <= {dq_r[WORD_W-2:0], 1'b0};
      end
    end
    if (ddone_r && !div_is_q_r) buckets_r <= dq_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (mode)
        MODE_T32: result <= {32'd0, prod_r[63:32]};
        MODE_T16: result <= {48'd0, prod_r[63:48]};
        MODE_T8:  result <= {56'd0, prod_r[63:56]};
        MODE_RNG: result <= (span == '0) ? prod_r : range_low + dq_r;
        default:  result <= prod_r;
      endcase
    end
  end

  assign sts.mul_done  = mdone_r;
  assign sts.div_done  = ddone_r;
  assign sts.span_zero = (span == '0);
  assign sts.reject    = (prod_r >= limit_r);
endmodule

### rtl/core/xsr_ctrl.sv
// Controller FSM: sequences seed writes, generator steps, the bucket
// division, limit multiply, rejection loop and result hand-off.
// Depends on xsr_pkg.
module xsr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [xsr_pkg::MODE_W-1:0]  mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output xsr_pkg::xsr_cmd_t           cmd,
  input  xsr_pkg::xsr_sts_t           sts
);
  import xsr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_LIM = 4'd2,
                         S_RD0 = 4'd3, S_RD1 = 4'd4, S_MIX = 4'd5,
                         S_MUL = 4'd6, S_CHK = 4'd7, S_QUO = 4'd8,
                         S_OUT = 4'd9, S_FIN = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic       ov_r, ov_nxt;
  logic       rng;

  assign rng = (mode == MODE_RNG) && !sts.span_zero;
  // The next draw may be accepted while the result still waits.
  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r;
    ov_nxt = ov_r && !out_ready;
    cmd    = '0;
    case (st_r)
      S_IDLE: if (in_valid && in_ready) begin
        if (in_func) cmd.seed_wr = 1'b1;
        else if (rng) begin
          cmd.div_start = 1'b1; st_nxt = S_DIV;
        end else begin
          cmd.rd_s0 = 1'b1; st_nxt = S_RD1;
        end
      end
      S_DIV: if (sts.div_done) begin st_nxt = S_LIM; end
      S_LIM: begin cmd.lim_start = 1'b1; st_nxt = S_RD0; end
      S_RD0: if (sts.mul_done) begin cmd.rd_s0 = 1'b1; st_nxt = S_RD1; end
      S_RD1: begin cmd.rd_s1 = 1'b1; st_nxt = S_MIX; end
      S_MIX: begin cmd.mix = 1'b1; cmd.mul_start = 1'b1; st_nxt = S_MUL; end
      S_MUL: if (sts.mul_done) st_nxt = rng ? S_CHK : S_OUT;
      S_CHK: if (sts.reject) begin
        cmd.rd_s0 = 1'b1; st_nxt = S_RD1;
      end else begin
        cmd.quo_start = 1'b1; st_nxt = S_QUO;
      end
      S_QUO: if (sts.div_done) st_nxt = S_OUT;
      S_OUT: if (!ov_r || out_ready) begin
        cmd.out_load = 1'b1; st_nxt = S_FIN;
      end
      S_FIN: begin ov_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

### rtl/core/xorshift1024_star_ranged_draw.sv
// Channel   Dir  Payload
// in        in   func, seed_index[3:0], seed_value[63:0]
// out       out  value[63:0]
// cfg       in   cfg_we, cfg_index[1:0], cfg_data[63:0]
// A shaped draw does two pool RAM reads, the mix and a 16-bit-slice
// multiply. A ranged draw adds a bit-serial bucket division and a
// limit multiply before the draw, a fresh generator step for each
// rejection and a final bit-serial quotient. Reset clears the
// pointer and control state and resets the config registers; pool
// words read as zero until written. A stalled result holds and
// blocks the next draw's hand-off.
module xorshift1024_star_ranged_draw (
  input  logic          clk,
  input  logic          rst_n,
  xsr_if.sink           in_ch,
  xsr_if.source         out_ch,
  input  logic          cfg_we,
  input  logic [xsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xsr_pkg::WORD_W-1:0]    cfg_data
);
  import xsr_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic [WORD_W-1:0] low_r, high_r;
  xsr_cmd_t          cmd;
  xsr_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FULL;
      low_r  <= '0;
      high_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_LOW:  low_r  <= cfg_data;
        REG_HIGH: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  xsr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(in_ch.data[68]),
    .mode(mode_r), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  xsr_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .seed_index(in_ch.data[67:64]), .seed_value(in_ch.data[63:0]),
    .mode(mode_r), .range_low(low_r), .range_high(high_r),
    .result(out_ch.data)
  );

  a_no_mix_on_seed: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.seed_wr && cmd.mix)) else $error("seed write during mix");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
    else $error("result changed while stalled");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten");
endmodule

### tb/testbench.sv
// Self-checking testbench for the xorshift1024* ranged draw block.
// Depends on xsr_pkg, xsr_if and xorshift1024_star_ranged_draw; predicts
// every draw in SystemVerilog and checks the results in order.
module testbench;
  import xsr_pkg::*;

  localparam int unsigned IN_W    = 1 + PTR_W + WORD_W;
  localparam int unsigned DRAIN   = 400;
  localparam int unsigned WD_MAX  = 40000;
  localparam int unsigned N_RAND  = 170;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  xsr_if #(.W(IN_W))   in_if (clk);
  xsr_if #(.W(WORD_W)) out_if (clk);

  xorshift1024_star_ranged_draw dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the generator state and the registers.
  logic [63:0]      pool_m [POOL_N];
  logic [PTR_W-1:0] ptr_m;
  logic [MODE_W-1:0] mode_m;
  logic [63:0]      low_m, high_m;

  logic [IN_W-1:0] pending_reqs [$];
  logic [63:0]     expected_values [$];
  int errors, draws_checked, seeds_sent;
  bit calm, hold_go, hold_seen;
  int hold_cnt, idle_cycles;

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] step_generator();
    logic [63:0] s0, s1;
    s0 = pool_m[ptr_m];
    ptr_m = ptr_m + 1'b1;
    s1 = pool_m[ptr_m];
    s1 = s1 ^ (s1 << 31);
    pool_m[ptr_m] = s1 ^ s0 ^ (s1 >> 11) ^ (s0 >> 30);
    return pool_m[ptr_m] * MULT;
  endfunction

  function automatic logic [63:0] ranged_value();
    logic [63:0] span, buckets, limit, cand;
    span = high_m - low_m + 64'd1;
    if (span == 64'd0) return step_generator();
    buckets = 64'hFFFF_FFFF_FFFF_FFFF / span;
    limit = buckets * span;
    do cand = step_generator(); while (cand >= limit);
    return low_m + cand / buckets;
  endfunction

  // Applies one accepted request to the shadow state.
  function automatic void predict_request(logic [IN_W-1:0] req);
    logic [63:0] r;
    if (req[IN_W-1]) begin
      pool_m[req[WORD_W+:PTR_W]] = req[WORD_W-1:0];
      ptr_m = '0;
      return;
    end
    case (mode_m)
      MODE_T32: r = step_generator() >> 32;
      MODE_T16: r = step_generator() >> 48;
      MODE_T8:  r = step_generator() >> 56;
      MODE_RNG: r = ranged_value();
      default:  r = step_generator();
    endcase
    expected_values.push_back(r);
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    logic         nv;
    logic [IN_W-1:0] nd;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      nv = in_if.valid;
      nd = in_if.data;
      if (in_if.valid && in_if.ready) begin
        predict_request(in_if.data);
        if (in_if.data[IN_W-1]) seeds_sent++;
        nv = 1'b0;
      end
      if (!nv && pending_reqs.size() > 0 && !roll_idle()) begin
        nd = pending_reqs.pop_front();
        nv = 1'b1;
      end
      in_if.valid <= nv;
      in_if.data  <= nd;
    end
  end

  // Result ready, with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt = 0;
      hold_seen = 1'b0;
    end else begin
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !roll_idle();
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_values.size() == 0) begin
        $error("unexpected result value=%h", out_if.data);
        errors++;
      end else begin
        logic [63:0] e;
        e = expected_values.pop_front();
        if (out_if.data !== e) begin
          $error("value: expected %h actual %h", e, out_if.data);
          errors++;
        end
        draws_checked++;
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_MAX) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("xorshift1024_star_ranged_draw: mismatch");
      $finish;
    end
  end

  task automatic push_draw();
    pending_reqs.push_back({1'b0, PTR_W'($urandom), 64'($urandom)});
  endtask

  task automatic push_seed(logic [3:0] idx, logic [63:0] v);
    pending_reqs.push_back({1'b1, idx, v});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_if.valid || expected_values.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: mode_m = v[MODE_W-1:0];
      REG_LOW:  low_m  = v;
      REG_HIGH: high_m = v;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [MODE_W-1:0] m, logic [63:0] lo, logic [63:0] hi);
    wait_idle();
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
  endtask

  initial begin
    logic [MODE_W-1:0] modes [12];
    logic [63:0] lows [12], highs [12];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_go = 1'b0;
    errors = 0;
    draws_checked = 0;
    seeds_sent = 0;
    idle_cycles = 0;
    foreach (pool_m[i]) pool_m[i] = '0;
    ptr_m = '0;
    mode_m = MODE_FULL;
    low_m = '0;
    high_m = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // An all-zero pool draws zero forever; ranged draws then return the low bound.
    for (int i = 0; i < POOL_N; i++) push_seed(4'(i), 64'd0);
    push_draw();
    push_draw();
    set_config(MODE_RNG, 64'd7, 64'd20);
    push_draw();
    // Seed with extremes, then one draw per mode.
    for (int i = 0; i < POOL_N; i++)
      push_seed(4'(i), (i == 0 || i == 15) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64());
    push_draw();
    for (int m = 0; m < 8; m++) begin
      set_config(MODE_W'(m), 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_draw();
    end
    set_config(MODE_RNG, 64'hFFFF_FFFF_FFFF_FFF0, 64'd3);
    push_draw();
    set_config(MODE_RNG, 64'd0, 64'h8000_0000_0000_0000);
    push_draw();
    push_draw();

    modes = '{MODE_FULL, MODE_T32, MODE_T16, MODE_T8, MODE_RNG, MODE_RNG,
              MODE_RNG, MODE_RNG, MODE_RNG, 3'd5, 3'd6, 3'd7};
    lows  = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd5, 64'hFFFF_FFFF_FFFF_FFFC,
              64'd0, rand64(), 64'd0, 64'd0, 64'd0};
    highs = '{'1, '1, '1, '1, '1, 64'd5, 64'd10, 64'h8000_0000_0000_0000,
              rand64(), '1, '1, '1};
    for (int p = 0; p < 12; p++) begin
      set_config(modes[p], lows[p], highs[p]);
      calm = (p == 2);
      if (p == 6) hold_go = !hold_go;
      for (int k = 0; k < N_RAND; k++) begin
        if ($urandom_range(99) < 12)
          push_seed(4'($urandom), ($urandom_range(9) == 0) ? 64'd0 : rand64());
        else
          push_draw();
      end
    end
    calm = 1'b0;
    wait_idle();

    $display("checked %0d draws and %0d seed writes over all output modes and range settings",
             draws_checked, seeds_sent);
    if (errors == 0)
      $display("xorshift1024_star_ranged_draw: match");
    else
      $display("xorshift1024_star_ranged_draw: mismatch");
    $finish;
  end
endmodule
